@@ hw/rtl/isf_pkg.sv @@
// isf_pkg: types and constants used by the info frame stuffing framer.
// No dependencies.
package isf_pkg;

	localparam int unsigned NUM_SLOTS = 8;

	typedef logic [7:0] byte_t;
	typedef logic [$clog2(NUM_SLOTS)-1:0] slot_idx_t;
	typedef logic [NUM_SLOTS-1:0][7:0] slots_t;

	typedef enum logic [2:0] {
		REG_FLAG      = 3'd0,
		REG_ESCAPE    = 3'd1,
		REG_ADDRESS   = 3'd2,
		REG_CTRL_SEQ0 = 3'd3,
		REG_CTRL_SEQ1 = 3'd4
	} reg_idx_t;

	localparam byte_t STUFF_FOR_FLAG   = 8'h5E;
	localparam byte_t STUFF_FOR_ESCAPE = 8'h5D;

	localparam byte_t FLAG_RST    = 8'h7E;
	localparam byte_t ESCAPE_RST  = 8'h7D;
	localparam byte_t ADDRESS_RST = 8'h03;
	localparam byte_t CTRL0_RST   = 8'h00;
	localparam byte_t CTRL1_RST   = 8'h40;

	localparam slot_idx_t HDR_LEN = slot_idx_t'(4);

endpackage

@@ hw/rtl/info_frame_stuffing_framer.sv @@
// info_frame_stuffing_framer: builds stuffed information frames with an xor check.
// Depends on isf_pkg.
//
// Each accepted payload byte is expanded at once into its full list of output
// bytes (header when first, the payload byte or its stuffed pair, check and
// closing flag when last) and held in an expansion register; the list then
// drains through an output register at one byte per cycle while the output is
// not stalled. An item causes 1 or 2 beats in the body of a frame, up to 8 for a
// one-byte frame. The next item is taken in the cycle the previous item's
// final beat moves into the output register, so back-to-back items see no gap.
// The running check is updated when an item is taken. Configuration writes
// never stall (cfg_ready is tied high); indexes beyond the register list are
// ignored.
module info_frame_stuffing_framer (
	input  logic       clk,
	input  logic       arst_n,
	// payload channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       sequence_bit,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       frame_end,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	isf_pkg::byte_t flag_q, escape_q, address_q, ctrl0_q, ctrl1_q;
	isf_pkg::byte_t check_q;

	// expansion register
	logic               valid_s1;
	isf_pkg::slots_t    slots_s1;
	isf_pkg::slot_idx_t last_idx_s1;
	logic               last_s1;
	isf_pkg::slot_idx_t idx_q;

	// expansion logic
	isf_pkg::slots_t    slots;
	isf_pkg::slot_idx_t base, after, last_idx;
	isf_pkg::byte_t     ctrl, pay0, pay1, check_run;
	logic               stuffed;

	logic in_accept, load_out, final_beat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q    <= isf_pkg::FLAG_RST;
			escape_q  <= isf_pkg::ESCAPE_RST;
			address_q <= isf_pkg::ADDRESS_RST;
			ctrl0_q   <= isf_pkg::CTRL0_RST;
			ctrl1_q   <= isf_pkg::CTRL1_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				isf_pkg::REG_FLAG:      flag_q    <= cfg_data;
				isf_pkg::REG_ESCAPE:    escape_q  <= cfg_data;
				isf_pkg::REG_ADDRESS:   address_q <= cfg_data;
				isf_pkg::REG_CTRL_SEQ0: ctrl0_q   <= cfg_data;
				isf_pkg::REG_CTRL_SEQ1: ctrl1_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		slots     = '0;
		stuffed   = 1'b0;
		pay1      = isf_pkg::STUFF_FOR_ESCAPE;
		ctrl      = sequence_bit ? ctrl1_q : ctrl0_q;
		// flag wins when flag and escape match
		if (data_byte == flag_q) begin
			stuffed = 1'b1;
			pay1    = isf_pkg::STUFF_FOR_FLAG;
		end else if (data_byte == escape_q) begin
			stuffed = 1'b1;
		end
		pay0 = stuffed ? escape_q : data_byte;
		check_run = (first_byte ? 8'h00 : check_q) ^ pay0 ^ (stuffed ? pay1 : 8'h00);

		if (first_byte) begin
			slots[0] = flag_q;
			slots[1] = address_q;
			slots[2] = ctrl;
			slots[3] = address_q ^ ctrl;
		end
		base = first_byte ? isf_pkg::HDR_LEN : '0;
		slots[base]                             = pay0;
		slots[base + isf_pkg::slot_idx_t'(1)]   = pay1;
		after = base + (stuffed ? isf_pkg::slot_idx_t'(2) : isf_pkg::slot_idx_t'(1));
		if (last_byte) begin
			slots[after]                          = check_run;
			slots[after + isf_pkg::slot_idx_t'(1)] = flag_q;
			last_idx = after + isf_pkg::slot_idx_t'(1);
		end else begin
			last_idx = after - isf_pkg::slot_idx_t'(1);
		end
	end

	assign load_out   = valid_s1 && (!out_valid || out_ready);
	assign final_beat = idx_q == last_idx_s1;
	assign in_ready   = !valid_s1 || (load_out && final_beat);
	assign in_accept  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= '0;
		end else if (in_accept) begin
			check_q <= last_byte ? 8'h00 : check_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_accept) begin
				valid_s1 <= 1'b1;
				idx_q    <= '0;
			end else if (load_out) begin
				if (final_beat) begin
					valid_s1 <= 1'b0;
				end
				idx_q <= idx_q + isf_pkg::slot_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			slots_s1    <= slots;
			last_idx_s1 <= last_idx;
			last_s1     <= last_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte  <= slots_s1[idx_q];
			run_last  <= final_beat;
			frame_end <= final_beat && last_s1;
		end
	end

endmodule

@@ hw/rtl/isf_checker.sv @@
// isf_checker: port-level checks for info_frame_stuffing_framer, bound into that module.
// Depends on info_frame_stuffing_framer's port list.
module isf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       frame_end,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	// closing flag is always the final beat of its item
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame_end without run_last");

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
			&& $stable(frame_end))
		else $error("stalled output beat changed");

	// configuration writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg write stalled");

	// an input accepted while the output is empty reaches out_valid through the expansion and output registers
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |-> ##2 out_valid)
		else $error("accepted item produced no beat");

endmodule

bind info_frame_stuffing_framer isf_checker u_isf_checker (.*);
